### design/chts_pkg.sv
// Shared types, constants and codes for the cache tag store.
package chts_pkg;

    localparam int LINES_DEF     = 256;
    localparam int WAYS_DEF      = 4;
    localparam int ADDR_BITS_DEF = 32;

    // Widths sized for the largest supported store (4096 lines).
    localparam int IDX_W   = 12;
    localparam int GRP_W   = IDX_W + 1;
    localparam int TAG_W   = 32;
    localparam int AGE_W   = 8;
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [3:0] MAX_OFFSET_BITS = 4'd12;
    localparam logic [3:0] MIN_LINE_BITS   = 4'd2;
    localparam logic [AGE_W-1:0] AGE_MAX   = '1;

    localparam logic [1:0] ORG_DIRECT = 2'd0;
    localparam logic [1:0] ORG_SET    = 2'd1;
    localparam logic [1:0] ORG_FULL   = 2'd2;

    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ORGANIZATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BITS    = 2'd3;

    // Search record that ripples down the cell chain.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [AGE_W-1:0] hit_age;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic             seen;
        logic [AGE_W-1:0] max_age;
        logic [IDX_W-1:0] max_idx;
    } scan_rec_t;

    localparam scan_rec_t SCAN_REC_EMPTY = '0;

    // Lookup broadcast to every cell: tag and group bounds [lo, hi).
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [GRP_W-1:0] lo;
        logic [GRP_W-1:0] hi;
    } query_t;

    // Update broadcast to every cell at commit.
    typedef struct packed {
        logic             en;
        logic             hit;
        logic             lru;
        logic [IDX_W-1:0] where_idx;
        logic [AGE_W-1:0] where_age;
        logic [IDX_W-1:0] victim_idx;
    } update_t;

endpackage

### design/chts_addr_if.sv
// Request channel carrying one byte address per word.
interface chts_addr_if
    import chts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

### design/chts_result_if.sv
// Result channel carrying hit flag and access number per word.
interface chts_result_if
    import chts_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [CNT_W-1:0] access_number;

    modport source (output valid, output hit, output access_number, input ready);
    modport sink   (input valid, input hit, input access_number, output ready);
endinterface

### design/chts_cell.sv
// One tag store line: holds tag, valid and age, and merges its line into the search record.
module chts_cell
    import chts_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      scan_en,
    input  query_t    query,
    input  update_t   upd,
    input  scan_rec_t rec_in,
    output scan_rec_t rec_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [GRP_W-1:0] MY_GRP = GRP_W'(CELL_IDX);

    logic [TAG_W-1:0] tag_reg, tag_next;
    logic             valid_reg, valid_next;
    logic [AGE_W-1:0] age_reg, age_next;
    scan_rec_t        rec_reg, rec_next;
    logic             in_group;
    logic [AGE_W-1:0] age_inc;

    assign in_group = (MY_GRP >= query.lo) && (MY_GRP < query.hi);
    assign age_inc  = (age_reg == AGE_MAX) ? age_reg : age_reg + AGE_W'(1);
    assign rec_out  = rec_reg;

    // Fold this line into the record.
    always_comb
    begin
        rec_next = rec_in;
        if (in_group)
        begin
            if (!rec_in.hit && valid_reg && tag_reg == query.tag)
            begin
                rec_next.hit     = 1'b1;
                rec_next.hit_idx = MY_IDX;
                rec_next.hit_age = age_reg;
            end
            if (!rec_in.free && !valid_reg)
            begin
                rec_next.free     = 1'b1;
                rec_next.free_idx = MY_IDX;
            end
            if (!rec_in.seen || age_reg > rec_in.max_age)
            begin
                rec_next.seen    = 1'b1;
                rec_next.max_age = age_reg;
                rec_next.max_idx = MY_IDX;
            end
        end
    end

    // Apply the commit decision to this line.
    always_comb
    begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        age_next   = age_reg;
        if (upd.en && in_group)
        begin
            if (upd.hit)
            begin
                if (upd.lru)
                begin
                    if (MY_IDX == upd.where_idx)
                        age_next = '0;
                    else if (valid_reg && age_reg < upd.where_age)
                        age_next = age_inc;
                end
            end
            else if (MY_IDX == upd.victim_idx)
            begin
                tag_next   = query.tag;
                valid_next = 1'b1;
                age_next   = '0;
            end
            else if (valid_reg)
            begin
                age_next = age_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        if (scan_en)
            rec_reg <= rec_next;
    end

endmodule

### design/cache_hit_miss_tag_store.sv
// Top level of the cache tag store: address split, cell chain, sequencer and result register.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-----------------------------------
//   req     | in  | valid / ready | address[31:0]
//   rsp     | out | valid / ready | hit, access_number[31:0]
//   cfg     | in  | cfg_we        | cfg_index[1:0], cfg_data[3:0]
//
// For each word the block latches the split address, lets the search
// record ripple one cell per scan cycle down the chain, and then commits
// the update and loads the result register once that register is free.
// Reset clears valid bits, ages, the access counter and the registers;
// the store needs no clearing pass. A stalled result holds in the
// result register; the next word is taken once the commit has happened.
module cache_hit_miss_tag_store
    import chts_pkg::*;
#(
    parameter int LINES     = LINES_DEF,
    parameter int WAYS      = WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    chts_addr_if.sink             req,
    chts_result_if.source         rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LINES_LOG2 = $clog2(LINES);
    localparam int WAYS_LOG2  = $clog2(WAYS);
    localparam int SCAN_W     = LINES_LOG2;
    localparam logic [3:0] MAX_LINE_BITS = 4'(LINES_LOG2);
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(LINES - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [1:0] org_reg;
    logic       policy_reg;
    logic [3:0] offset_reg;
    logic [3:0] line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg    <= ORG_DIRECT;
            policy_reg <= POL_FIFO;
            offset_reg <= 4'd4;
            line_reg   <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORGANIZATION: org_reg    <= cfg_data[1:0];
                REG_POLICY:       policy_reg <= cfg_data[0];
                REG_OFFSET_BITS:  offset_reg <= cfg_data;
                REG_LINE_BITS:    line_reg   <= cfg_data;
                default:          org_reg    <= org_reg;
            endcase
        end
    end

    // Split the address into group bounds and tag.
    logic [3:0]        ob, lb, sb;
    logic [ADDR_W-1:0] addr_m, blk;
    query_t            query_new, query_reg;

    always_comb
    begin
        ob = (offset_reg > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_reg;
        lb = line_reg;
        if (lb > MAX_LINE_BITS)
            lb = MAX_LINE_BITS;
        if (lb < MIN_LINE_BITS)
            lb = MIN_LINE_BITS;
        sb     = lb - 4'(WAYS_LOG2);
        addr_m = req.address & ADDR_MASK;
        blk    = addr_m >> ob;
        unique case (org_reg)
            ORG_DIRECT:
            begin
                query_new.lo  = GRP_W'(blk & ((ADDR_W'(1) << lb) - ADDR_W'(1)));
                query_new.hi  = query_new.lo + GRP_W'(1);
                query_new.tag = TAG_W'(blk >> lb);
            end
            ORG_SET:
            begin
                query_new.lo  = GRP_W'((blk & ((ADDR_W'(1) << sb) - ADDR_W'(1)))
                                       << WAYS_LOG2);
                query_new.hi  = query_new.lo + GRP_W'(WAYS);
                query_new.tag = TAG_W'(blk >> sb);
            end
            default:
            begin
                query_new.lo  = '0;
                query_new.hi  = GRP_W'(1) << lb;
                query_new.tag = TAG_W'(blk);
            end
        endcase
    end

    // Sequencer.
    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              req_fire, commit, out_free;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              hit_reg, hit_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    update_t           upd;
    scan_rec_t         rec_chain [LINES];
    scan_rec_t         rec_last;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign commit    = (state_reg == ST_COMMIT) && out_free;
    assign rec_last  = rec_chain[LINES-1];

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_cnt_next = '0;
                if (req_fire)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                if (scan_cnt_reg == SCAN_LAST)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Broadcast the decision taken from the end of the chain.
    always_comb
    begin
        upd.en         = commit;
        upd.hit        = rec_last.hit;
        upd.lru        = (policy_reg == POL_LRU);
        upd.where_idx  = rec_last.hit_idx;
        upd.where_age  = rec_last.hit_age;
        upd.victim_idx = rec_last.free ? rec_last.free_idx : rec_last.max_idx;
    end

    // Result register: load at commit, drop when taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        hit_next       = hit_reg;
        count_next     = count_reg;
        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
            hit_next       = rec_last.hit;
            count_next     = count_reg + CNT_W'(1);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = hit_reg;
    assign rsp.access_number = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            hit_reg       <= hit_next;
            count_reg     <= count_next;
        end
    end

    // Hold the split address for the whole word.
    always_ff @(posedge clk)
    begin
        if (req_fire)
            query_reg <= query_new;
    end

    // Chain of line cells; the record advances one cell per scan cycle.
    for (genvar k = 0; k < LINES; k++)
    begin : g_cell
        scan_rec_t rec_in;
        if (k == 0)
        begin : g_head
            assign rec_in = SCAN_REC_EMPTY;
        end
        else
        begin : g_body
            assign rec_in = rec_chain[k-1];
        end
        chts_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .scan_en (state_reg == ST_SCAN),
            .query   (query_reg),
            .upd     (upd),
            .rec_in  (rec_in),
            .rec_out (rec_chain[k])
        );
    end

endmodule

### dv/testbench.sv
// Self-checking testbench for the cache tag store: predicted hit/miss stream per address.
`timescale 1ns / 100ps

module testbench;
    import chts_pkg::*;

    localparam int NUM_LINES = LINES_DEF;
    localparam int MAX_LB    = 8;          // log2 of NUM_LINES
    localparam int IDLE_PCT  = 34;

    typedef struct {
        logic             hit;
        logic [CNT_W-1:0] access_number;
    } lookup_result_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    chts_addr_if   req_if ();
    chts_result_if rsp_if ();

    cache_hit_miss_tag_store u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the register file and the tag store.
    logic [1:0]       org_reg;
    logic             pol_reg;
    logic [3:0]       offset_reg;
    logic [3:0]       linebits_reg;
    logic [TAG_W-1:0] shadow_tag   [NUM_LINES];
    logic             shadow_valid [NUM_LINES];
    logic [AGE_W-1:0] shadow_age   [NUM_LINES];
    logic [CNT_W-1:0] shadow_count;

    lookup_result_t pending_results[$];

    bit gaps_on;          // random idling on both channels
    int hold_cycles;      // receiver hold-off request, consumed by the receiver
    int error_count;
    int words_sent;
    int words_checked;
    int hits_seen;

    // Clock: 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predict one lookup and advance the shadow store.
    function automatic lookup_result_t lookup_cache(input logic [ADDR_W-1:0] addr);
        lookup_result_t res;
        int unsigned ob;
        int unsigned lb;
        int unsigned ib;
        int unsigned base;
        int unsigned span;
        int unsigned where_idx;
        int unsigned victim;
        logic [1:0]  org;
        logic [31:0] blk;
        logic [31:0] tg;
        logic [AGE_W-1:0] hit_age;
        logic [AGE_W-1:0] best;
        bit found;
        bit first;
        res.hit = 1'b0;
        where_idx = 0;
        ob = (offset_reg > MAX_OFFSET_BITS) ? 12 : offset_reg;
        lb = linebits_reg;
        if (lb > MAX_LB) lb = MAX_LB;
        if (lb < 2) lb = 2;
        org = (org_reg > ORG_FULL) ? ORG_FULL : org_reg;
        blk = addr >> ob;
        if (org == ORG_DIRECT)
        begin
            base = blk & ((32'd1 << lb) - 1);
            span = 1;
            tg   = blk >> lb;
        end
        else if (org == ORG_SET)
        begin
            ib   = lb - 2;
            base = (blk & ((32'd1 << ib) - 1)) * WAYS_DEF;
            span = WAYS_DEF;
            tg   = blk >> ib;
        end
        else
        begin
            base = 0;
            span = 1 << lb;
            tg   = blk;
        end

        // Tag search: lowest valid matching line wins.
        for (int unsigned k = base; k < base + span && k < NUM_LINES; k++)
        begin
            if (shadow_valid[k] && shadow_tag[k] == tg)
            begin
                res.hit = 1'b1;
                where_idx = k;
                break;
            end
        end

        if (res.hit)
        begin
            // LRU hit: age the younger lines, refresh the hit line. FIFO: no change.
            if (pol_reg == POL_LRU)
            begin
                hit_age = shadow_age[where_idx];
                for (int unsigned k = base; k < base + span && k < NUM_LINES; k++)
                    if (k != where_idx && shadow_valid[k] && shadow_age[k] < hit_age
                        && shadow_age[k] != AGE_MAX)
                        shadow_age[k]++;
                shadow_age[where_idx] = '0;
            end
        end
        else
        begin
            // Victim: lowest free line, else the oldest (lowest index on a tie).
            found = 1'b0;
            victim = base;
            for (int unsigned k = base; k < base + span && k < NUM_LINES; k++)
            begin
                if (!shadow_valid[k])
                begin
                    victim = k;
                    found = 1'b1;
                    break;
                end
            end
            if (!found)
            begin
                first = 1'b1;
                best = '0;
                for (int unsigned k = base; k < base + span && k < NUM_LINES; k++)
                begin
                    if (first || shadow_age[k] > best)
                    begin
                        best = shadow_age[k];
                        victim = k;
                        first = 1'b0;
                    end
                end
            end
            for (int unsigned k = base; k < base + span && k < NUM_LINES; k++)
                if (k != victim && shadow_valid[k] && shadow_age[k] != AGE_MAX)
                    shadow_age[k]++;
            shadow_tag[victim]   = tg;
            shadow_valid[victim] = 1'b1;
            shadow_age[victim]   = '0;
        end

        shadow_count = shadow_count + 1;
        res.access_number = shadow_count;
        return res;
    endfunction

    // Offer one address word; hold valid high across back-to-back words.
    task automatic send_address(input logic [ADDR_W-1:0] addr);
        if (gaps_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_if.valid   <= 1'b1;
        req_if.address <= addr;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), lookup_cache(addr));
        words_sent++;
    endtask

    // Drop valid and wait until every expected result has been checked.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers, one per edge; only called with the block idle.
    task automatic write_config(input logic [1:0] org, input logic pol,
                                input logic [3:0] ob, input logic [3:0] lb);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idxs [4];
        vals = '{CFG_DATA_W'(org), CFG_DATA_W'(pol), ob, lb};
        idxs = '{REG_ORGANIZATION, REG_POLICY, REG_OFFSET_BITS, REG_LINE_BITS};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        org_reg      = org;
        pol_reg      = pol;
        offset_reg   = ob;
        linebits_reg = lb;
        @(posedge clk);
    endtask

    // Receiver: check each accepted word, then pick the next ready value.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected: hit=%0b access_number=%0d",
                           rsp_if.hit, rsp_if.access_number);
                    error_count++;
                end
                else
                begin
                    lookup_result_t want;
                    want = pending_results.pop_front();
                    if (rsp_if.hit !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, rsp_if.hit);
                        error_count++;
                    end
                    if (rsp_if.access_number !== want.access_number)
                    begin
                        $error("access_number: expected %0d, got %0d",
                               want.access_number, rsp_if.access_number);
                        error_count++;
                    end
                    words_checked++;
                    if (want.hit)
                        hits_seen++;
                end
            end
            // Long hold-off counts down here; otherwise stall at random while gaps are on.
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
            end
        end
    end

    // Reset state, default geometry: hits, same-block hits, conflict eviction, top address.
    task automatic test_direct_mapped();
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'h0000_000F);
        send_address(32'hFFFF_FFFF);
        send_address(32'h0000_1000);
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFF0);
        drain_results();
    endtask

    // One set of four ways: fill, evict the oldest, FIFO vs LRU ordering.
    task automatic test_set_assoc_policies();
        for (int p = 0; p < 2; p++)
        begin
            write_config(ORG_SET, p[0], 4'd0, 4'd0);   // line_bits clamps up to 2
            send_address(32'h10);
            send_address(32'h11);
            send_address(32'h12);
            send_address(32'h13);
            send_address(32'h10);                      // hit: refresh under LRU only
            send_address(32'h14);                      // evicts per policy
            send_address(32'h10);
            drain_results();
        end
    endtask

    // Fully associative with clamped fields and the unused organization code.
    task automatic test_full_assoc_clamps();
        write_config(2'd3, POL_LRU, 4'd15, 4'd15);
        send_address(32'h8000_0000);
        send_address(32'h8000_0FFF);
        send_address(32'h7FFF_F000);
        send_address(32'h8000_1000);
        drain_results();
        write_config(ORG_FULL, POL_FIFO, 4'd12, 4'd8);
        send_address(32'h0000_0FFF);
        send_address(32'hFFFF_FFFF);
        drain_results();
    endtask

    // Receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        write_config(ORG_SET, POL_LRU, 4'd2, 4'd4);
        hold_cycles = 1200;
        for (int i = 0; i < 20; i++)
            send_address($urandom_range(63));
        drain_results();
    endtask

    // Random phases: random geometry, then mostly reuse of a small address pool.
    task automatic test_random_traffic();
        logic [ADDR_W-1:0] pool [32];
        int pool_n;
        int phases;
        int quiet_phase;
        logic [3:0] ob;
        logic [3:0] lb;
        phases = 16;
        quiet_phase = $urandom_range(phases - 1);
        for (int ph = 0; ph < phases; ph++)
        begin
            gaps_on = (ph != quiet_phase);
            case (ph)
                0:       begin ob = 4'd0;  lb = 4'd2;  end
                1:       begin ob = 4'd12; lb = 4'd8;  end
                2:       begin ob = 4'd15; lb = 4'd0;  end
                default: begin ob = 4'($urandom_range(15)); lb = 4'($urandom_range(15)); end
            endcase
            write_config(2'(ph % 4), 1'($urandom_range(1)), ob, lb);
            pool_n = $urandom_range(2, 32);
            for (int i = 0; i < pool_n; i++)
                pool[i] = $urandom;
            // Cluster half the pool in nearby blocks so sets collide.
            for (int i = 0; i < pool_n / 2; i++)
                pool[i] = (pool[0] & 32'hFFFF_0000) | ($urandom_range(255) << ob);
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(99) < 80)
                    send_address(pool[$urandom_range(pool_n - 1)] ^ $urandom_range(3));
                else
                    send_address($urandom);
            end
            drain_results();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        clk = 1'b0;
        req_if.valid <= 1'b0;
        req_if.address <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        gaps_on = 1'b1;
        hold_cycles = 0;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        hits_seen = 0;
        org_reg = ORG_DIRECT;
        pol_reg = POL_FIFO;
        offset_reg = 4'd4;
        linebits_reg = 4'd8;
        shadow_count = '0;
        for (int k = 0; k < NUM_LINES; k++)
        begin
            shadow_tag[k] = '0;
            shadow_valid[k] = 1'b0;
            shadow_age[k] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_direct_mapped();
        test_set_assoc_policies();
        test_full_assoc_clamps();
        test_backpressure();
        test_random_traffic();

        $display("Covered all organizations and policies, clamped geometry and a long stall.");
        $display("Words sent %0d, results checked %0d, hits %0d, errors %0d.",
                 words_sent, words_checked, hits_seen, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #40ms;
        $display("Timeout: %0d results still expected.", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
